[rtl/dac_pkg.sv]
package dac_pkg;

  // Default number of entries
  localparam int unsigned DefaultDepth = 64;

  localparam int unsigned IndexW = 6;
  localparam int unsigned WordW  = 32;
  localparam int unsigned CountW = 7;

  typedef enum logic [1:0] {
    FUNC_APPEND = 2'd0,
    FUNC_READ   = 2'd1,
    FUNC_WRITE  = 2'd2,
    FUNC_REMOVE = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  // Request payload
  typedef struct packed {
    func_e                    func;
    logic [IndexW-1:0]        index;
    logic signed [WordW-1:0]  value;
  } in_req_t;

  // Result payload
  typedef struct packed {
    logic signed [WordW-1:0]  read_value;
    status_e                  status;
    logic [CountW-1:0]        count;
  } out_rsp_t;

  // Command broadcast to every cell
  typedef struct packed {
    logic                     go;      // accepted request that passed its checks
    func_e                    func;
    logic [IndexW-1:0]        index;
    logic signed [WordW-1:0]  value;
  } cell_cmd_t;

endpackage

[rtl/dac_cell.sv]
// One storage slot of the array. Takes a new word on append/write hits,
// or its upper neighbor's word while a remove compacts the array.
module dac_cell #(
  parameter int unsigned Pos = 0,
  parameter int unsigned CW  = 7
) (
  input  logic                              clk_i,
  input  dac_pkg::cell_cmd_t                cmd_i,
  input  logic [CW-1:0]                     count_i,
  input  logic signed [dac_pkg::WordW-1:0]  upper_i,
  output logic signed [dac_pkg::WordW-1:0]  data_o
);

  localparam int unsigned CmpW = (CW > dac_pkg::IndexW) ? CW : dac_pkg::IndexW;

  logic [CmpW-1:0] idx_w, cnt_w, pos_w, pos1_w;
  logic            hit_append, hit_write, do_shift;
  logic signed [dac_pkg::WordW-1:0] data_q, data_d;

  assign idx_w  = CmpW'(cmd_i.index);
  assign cnt_w  = CmpW'(count_i);
  assign pos_w  = CmpW'(Pos);
  assign pos1_w = CmpW'(Pos + 1);

  // Decode this slot's part of the request
  assign hit_append = cmd_i.go && (cmd_i.func == dac_pkg::FUNC_APPEND) && (cnt_w == pos_w);
  assign hit_write  = cmd_i.go && (cmd_i.func == dac_pkg::FUNC_WRITE) && (idx_w == pos_w);
  assign do_shift   = cmd_i.go && (cmd_i.func == dac_pkg::FUNC_REMOVE) &&
                      (pos_w >= idx_w) && (pos1_w < cnt_w);

  always_comb begin
    data_d = data_q;
    if (hit_append || hit_write) begin
      data_d = cmd_i.value;
    end else if (do_shift) begin
      data_d = upper_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

[rtl/indexed_array_with_compaction.sv]
// Packed array of signed 32-bit words with an element count, held in a row
// of Depth slots. Each request is append, read, write or remove-at-index;
// remove shifts every later slot down by one in the same cycle. Every
// request yields one result from an output register, so one request per
// cycle is sustained while the result side keeps up; in_stall_o rises
// only while a finished result waits to be taken.
// Read, write and remove with index not below count give out-of-range;
// append on a full array gives full. Neither changes any state.
module indexed_array_with_compaction #(
  parameter int unsigned Depth = dac_pkg::DefaultDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  dac_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output dac_pkg::out_rsp_t out_rsp_o
);

  localparam int unsigned CW   = $clog2(Depth + 1);
  localparam int unsigned CmpW = (CW > dac_pkg::IndexW) ? CW : dac_pkg::IndexW;

  logic [CW-1:0]  count_q, count_d;
  logic           accept, ok, in_range, is_full;
  logic [CmpW-1:0] idx_w, cnt_w;
  dac_pkg::status_e   status;
  dac_pkg::cell_cmd_t cmd;
  dac_pkg::out_rsp_t  rsp_q, rsp_d;
  logic               out_valid_q;
  logic signed [dac_pkg::WordW-1:0] data [Depth];
  logic signed [dac_pkg::WordW-1:0] rd_word;

  // Handshake: hold input while a result is pending and the output stalls
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  // Request checks
  assign idx_w    = CmpW'(in_req_i.index);
  assign cnt_w    = CmpW'(count_q);
  assign in_range = idx_w < cnt_w;
  assign is_full  = (count_q == CW'(Depth));

  always_comb begin
    status = dac_pkg::STATUS_OK;
    if (in_req_i.func == dac_pkg::FUNC_APPEND) begin
      if (is_full) status = dac_pkg::STATUS_FULL;
    end else if (!in_range) begin
      status = dac_pkg::STATUS_RANGE;
    end
  end

  assign ok = (status == dac_pkg::STATUS_OK);

  // Broadcast command to the row of cells
  assign cmd.go    = accept && ok;
  assign cmd.func  = in_req_i.func;
  assign cmd.index = in_req_i.index;
  assign cmd.value = in_req_i.value;

  for (genvar k = 0; k < Depth; k++) begin : g_cell
    logic signed [dac_pkg::WordW-1:0] upper;
    if (k + 1 < Depth) begin : g_mid
      assign upper = data[k+1];
    end else begin : g_top
      assign upper = data[k];
    end
    dac_cell #(
      .Pos (k),
      .CW  (CW)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .count_i (count_q),
      .upper_i (upper),
      .data_o  (data[k])
    );
  end

  // Read select over the cells
  always_comb begin
    rd_word = '0;
    for (int unsigned k = 0; k < Depth; k++) begin
      if (idx_w == CmpW'(k)) rd_word = data[k];
    end
  end

  // Element count update
  always_comb begin
    count_d = count_q;
    if (cmd.go) begin
      case (in_req_i.func)
        dac_pkg::FUNC_APPEND: count_d = count_q + CW'(1);
        dac_pkg::FUNC_REMOVE: count_d = count_q - CW'(1);
        default:              count_d = count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Result register
  always_comb begin
    rsp_d.status     = status;
    rsp_d.count      = dac_pkg::CountW'(count_d);
    rsp_d.read_value = (ok && in_req_i.func == dac_pkg::FUNC_READ) ? rd_word : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule
